/* src/psu_pkg.sv */
// psu_pkg: shared types and constants for the PNG scanline unfilter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package psu_pkg;

    // Field widths fixed by the interface
    localparam int BYTE_W   = 8;
    localparam int FILT_W   = 3;
    localparam int BPP_W    = 4;
    localparam int RB_W     = 14;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 14;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PIXEL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES       = 1'd1;

    // Row filter codes
    localparam logic [FILT_W-1:0] FILT_NONE  = 3'd0;
    localparam logic [FILT_W-1:0] FILT_SUB   = 3'd1;
    localparam logic [FILT_W-1:0] FILT_UP    = 3'd2;
    localparam logic [FILT_W-1:0] FILT_AVG   = 3'd3;
    localparam logic [FILT_W-1:0] FILT_PAETH = 3'd4;

    // Input transaction payload
    typedef struct packed {
        logic [BYTE_W-1:0] filtered_byte;
        logic [FILT_W-1:0] filter_type;
        logic              image_start;
    } in_t;

    // Result transaction payload
    typedef struct packed {
        logic [BYTE_W-1:0] pixel_byte;
        logic              row_last;
        logic              bad_filter;
    } out_t;

    // Classified byte handed from front to back (line store address travels beside it)
    typedef struct packed {
        logic [BYTE_W-1:0] filtered_byte;
        logic [FILT_W-1:0] row_filter;
        logic              has_left;   // column >= bytes per pixel
        logic              prior_ok;   // previous row is valid
        logic              row_last;
        logic [2:0]        bpp_idx;    // bytes per pixel minus one
    } q_entry_t;

endpackage

/* src/psu_front.sv */
// psu_front: accepts filtered bytes, tracks column, row filter and row validity.
// Depends on psu_pkg; feeds the classified byte queue.
`timescale 1ns / 1ps

module psu_front #(
    parameter int MAX_ROW_BYTES = 8192,
    parameter int AW            = $clog2(MAX_ROW_BYTES)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  psu_pkg::in_t                s_data,
    input  logic [psu_pkg::BPP_W-1:0]   bytes_per_pixel,
    input  logic [psu_pkg::RB_W-1:0]    row_bytes,
    input  logic                        q_full,
    output logic                        q_push,
    output psu_pkg::q_entry_t           q_entry,
    output logic [AW-1:0]               q_addr
);
    import psu_pkg::*;

    localparam int CW = $clog2(MAX_ROW_BYTES + 1);
    localparam int LW = (CW > RB_W) ? CW : RB_W;
    localparam logic [LW-1:0] MAX_L = LW'(MAX_ROW_BYTES);

    logic [AW-1:0]     col_reg, col_next;
    logic [FILT_W-1:0] rf_reg, rf_next;
    logic              pv_reg, pv_next;

    logic [LW-1:0]     rb_eff, col_l, x_l;
    logic [BPP_W-1:0]  bpp_eff;
    logic              pv_cur, last;
    logic [FILT_W-1:0] rf_cur;

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;

    // Clamp configuration to its legal range
    always_comb begin
        if (row_bytes == '0) begin
            rb_eff = LW'(1);
        end else if (LW'(row_bytes) > MAX_L) begin
            rb_eff = MAX_L;
        end else begin
            rb_eff = LW'(row_bytes);
        end
        if (bytes_per_pixel == '0) begin
            bpp_eff = BPP_W'(1);
        end else if (bytes_per_pixel > BPP_W'(8)) begin
            bpp_eff = BPP_W'(8);
        end else begin
            bpp_eff = bytes_per_pixel;
        end
    end

    // Column, filter and validity for the byte on the port
    always_comb begin
        col_l  = s_data.image_start ? '0 : LW'(col_reg);
        pv_cur = s_data.image_start ? 1'b0 : pv_reg;
        x_l    = (col_l >= rb_eff) ? (rb_eff - LW'(1)) : col_l;
        rf_cur = (x_l == '0) ? s_data.filter_type : rf_reg;
        last   = ((x_l + LW'(1)) >= rb_eff);

        q_addr                 = x_l[AW-1:0];
        q_entry.filtered_byte  = s_data.filtered_byte;
        q_entry.row_filter     = rf_cur;
        q_entry.has_left       = (x_l >= LW'(bpp_eff));
        q_entry.prior_ok       = pv_cur;
        q_entry.row_last       = last;
        q_entry.bpp_idx        = 3'(bpp_eff - BPP_W'(1));

        col_next = col_reg;
        rf_next  = rf_reg;
        pv_next  = pv_reg;
        if (q_push) begin
            rf_next  = rf_cur;
            col_next = last ? '0 : AW'(x_l + LW'(1));
            pv_next  = last ? 1'b1 : pv_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            rf_reg  <= FILT_NONE;
            pv_reg  <= 1'b0;
        end else begin
            col_reg <= col_next;
            rf_reg  <= rf_next;
            pv_reg  <= pv_next;
        end
    end

endmodule

/* src/psu_queue.sv */
// psu_queue: two-entry FIFO that decouples the front from the back.
// Depends on psu_pkg only by convention; payload is a flat vector.
`timescale 1ns / 1ps

module psu_queue #(
    parameter int W = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic         head_valid,
    output logic [W-1:0] head_data
);
    import psu_pkg::*;

    logic [W-1:0] slot_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_data  = slot_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload slots, no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* src/psu_back.sv */
// psu_back: line store read, prediction (none/sub/up/average/paeth) and result register.
// Depends on psu_pkg; pops classified bytes from psu_queue.
`timescale 1ns / 1ps

module psu_back #(
    parameter int MAX_ROW_BYTES = 8192,
    parameter int AW            = $clog2(MAX_ROW_BYTES)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  psu_pkg::q_entry_t  q_entry,
    input  logic [AW-1:0]      q_addr,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output psu_pkg::out_t      m_data
);
    import psu_pkg::*;

    // Paeth predictor, ties go to left, then above
    function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
        logic signed [10:0] pa, pb, pc;
        pa = $signed({3'b000, b}) - $signed({3'b000, c});
        pb = $signed({3'b000, a}) - $signed({3'b000, c});
        pc = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({2'b00, c, 1'b0});
        if (pa < 0) pa = -pa;
        if (pb < 0) pb = -pb;
        if (pc < 0) pc = -pc;
        if (pa <= pb && pa <= pc) return a;
        if (pb <= pc) return b;
        return c;
    endfunction

    logic [7:0]    line_mem [MAX_ROW_BYTES];

    logic          ex_valid_reg;
    q_entry_t      ex_reg;
    logic [AW-1:0] ex_addr_reg;
    logic [7:0]    rdata_reg;
    logic          fwd_reg;
    logic [7:0]    fwd_data_reg;
    logic [63:0]   left_hist_reg, left_hist_next;
    logic [63:0]   ul_hist_reg, ul_hist_next;
    logic          m_valid_reg;
    out_t          m_data_reg;

    logic          fire;
    logic [5:0]    hsel;
    logic [7:0]    above, left, ul, pred, result;
    logic [8:0]    avg_sum;

    assign fire    = ex_valid_reg && (!m_valid_reg || m_ready);
    assign q_pop   = q_valid && (!ex_valid_reg || fire);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Neighbors and prediction for the byte in the execute register
    always_comb begin
        hsel    = {ex_reg.bpp_idx, 3'b000};
        above   = ex_reg.prior_ok ? (fwd_reg ? fwd_data_reg : rdata_reg) : 8'd0;
        left    = ex_reg.has_left ? left_hist_reg[hsel +: 8] : 8'd0;
        ul      = (ex_reg.has_left && ex_reg.prior_ok) ? ul_hist_reg[hsel +: 8] : 8'd0;
        avg_sum = {1'b0, left} + {1'b0, above};
        case (ex_reg.row_filter)
            FILT_SUB:   pred = left;
            FILT_UP:    pred = above;
            FILT_AVG:   pred = avg_sum[8:1];
            FILT_PAETH: pred = paeth(left, above, ul);
            default:    pred = 8'd0;
        endcase
        result         = ex_reg.filtered_byte + pred;
        left_hist_next = fire ? {left_hist_reg[55:0], result} : left_hist_reg;
        ul_hist_next   = fire ? {ul_hist_reg[55:0], above} : ul_hist_reg;
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ex_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            left_hist_reg <= '0;
            ul_hist_reg   <= '0;
        end else begin
            if (q_pop) begin
                ex_valid_reg <= 1'b1;
            end else if (fire) begin
                ex_valid_reg <= 1'b0;
            end
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            left_hist_reg <= left_hist_next;
            ul_hist_reg   <= ul_hist_next;
        end
    end

    // Payload registers; a same-cycle write to the popped address is forwarded
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            ex_reg       <= q_entry;
            ex_addr_reg  <= q_addr;
            fwd_reg      <= fire && (ex_addr_reg == q_addr);
            fwd_data_reg <= result;
        end
        if (fire) begin
            m_data_reg.pixel_byte <= result;
            m_data_reg.row_last   <= ex_reg.row_last;
            m_data_reg.bad_filter <= (ex_reg.row_filter > FILT_PAETH);
        end
    end

    // Previous-row line store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (fire) begin
            line_mem[ex_addr_reg] <= result;
        end
        if (q_pop) begin
            rdata_reg <= line_mem[q_addr];
        end
    end

endmodule

/* src/png_scanline_unfilter.sv */
// png_scanline_unfilter: PNG scanline filter reconstruction, one byte per transaction.
// Datapath: queue slot, execute register, result register. Throughput: one byte per cycle
// while m_ready is high; the sub/paeth feedback from result to left neighbor closes in the
// single execute stage. Reset (aresetn low, synchronous) empties the
// queue and pipeline, clears column, row validity and history, and sets
// bytes_per_pixel and row_bytes to 1; the line store is not cleared.
`timescale 1ns / 1ps

module png_scanline_unfilter #(
    parameter int MAX_ROW_BYTES = 8192
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  psu_pkg::in_t                    s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output psu_pkg::out_t                   m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [psu_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [psu_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import psu_pkg::*;

    localparam int AW = $clog2(MAX_ROW_BYTES);
    localparam int QW = AW + $bits(q_entry_t);

    logic [BPP_W-1:0] bpp_reg;
    logic [RB_W-1:0]  rb_reg;

    logic             q_full, q_push, q_pop, q_valid;
    q_entry_t         push_entry, head_entry;
    logic [AW-1:0]    push_addr, head_addr;
    logic [QW-1:0]    head_bits;

    // Configuration registers, always ready
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpp_reg <= BPP_W'(1);
            rb_reg  <= RB_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_BYTES_PER_PIXEL: bpp_reg <= cfg_data[BPP_W-1:0];
                CFG_ROW_BYTES:       rb_reg  <= cfg_data[RB_W-1:0];
                default:             ;
            endcase
        end
    end

    psu_front #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES),
        .AW            (AW)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .bytes_per_pixel (bpp_reg),
        .row_bytes       (rb_reg),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_entry         (push_entry),
        .q_addr          (push_addr)
    );

    psu_queue #(
        .W (QW)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  ({push_addr, push_entry}),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (head_bits)
    );

    assign head_addr  = head_bits[QW-1 -: AW];
    assign head_entry = q_entry_t'(head_bits[$bits(q_entry_t)-1:0]);

    psu_back #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES),
        .AW            (AW)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_entry (head_entry),
        .q_addr  (head_addr),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

/* src/psu_checker.sv */
// psu_checker: port-level assertions for png_scanline_unfilter, attached by bind.
// Depends on psu_pkg and the top level's port list.
`timescale 1ns / 1ps

module psu_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input psu_pkg::out_t m_data,
    input logic          m_valid,
    input logic          m_ready
);
    import psu_pkg::*;

    // A stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Reset empties the result register
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // Reset empties the queue, so input is taken right away
    a_reset_in: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready right after reset");

    // Nothing comes out in the cycle after reset and an idle cycle
    a_no_invent: assert property (@(posedge aclk)
        !aresetn ##1 (aresetn && !s_valid) |=> !m_valid)
        else $error("result appeared with no input");

endmodule

bind png_scanline_unfilter psu_checker u_psu_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_data  (m_data),
    .m_valid (m_valid),
    .m_ready (m_ready)
);
